### design/c_like_lexeme_splitter_top_defines.svh
// assertion macros for the lexeme splitter
`ifndef C_LIKE_LEXEME_SPLITTER_TOP_DEFINES_SVH
`define C_LIKE_LEXEME_SPLITTER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lls_pkg.sv
// types, constants and character classes for the lexeme splitter
package lls_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam logic [1:0] KIND_IDENT  = 2'd0;
  localparam logic [1:0] KIND_NUMBER = 2'd1;
  localparam logic [1:0] KIND_PUNCT  = 2'd2;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_D          = 8'h64;
  localparam logic [7:0] CH_F          = 8'h66;
  localparam logic [7:0] CH_C          = 8'h63;
  localparam logic [7:0] CH_S          = 8'h73;
  localparam logic [7:0] CH_N          = 8'h6E;
  localparam logic [7:0] CH_T          = 8'h74;
  localparam logic [7:0] CH_R          = 8'h72;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_EQ         = 8'h3D;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_BSLASH     = 8'h5C;
  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_PIPE       = 8'h7C;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_LBRACK     = 8'h5B;
  localparam logic [7:0] CH_RBRACK     = 8'h5D;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_UP_A       = 8'h41;
  localparam logic [7:0] CH_UP_Z       = 8'h5A;
  localparam logic [7:0] CH_LO_A       = 8'h61;
  localparam logic [7:0] CH_LO_Z       = 8'h7A;
  localparam logic [7:0] CH_0          = 8'h30;
  localparam logic [7:0] CH_9          = 8'h39;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_PUNCT
  } mode_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       begins_lexeme;
    logic [1:0] lexeme_kind;
    logic       end_of_stream;
    logic       last_of_run;
  } out_word_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) ||
           (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic is_single_punct(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACK) ||
           (c == CH_RBRACK) || (c == CH_LBRACE) || (c == CH_RBRACE) ||
           (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_DOT) ||
           (c == CH_SQUOTE) || (c == CH_DQUOTE);
  endfunction

  function automatic logic is_opener(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_EQ) || (c == CH_LT) || (c == CH_GT) ||
           (c == CH_BANG) || (c == CH_PERCENT) || (c == CH_BSLASH) ||
           (c == CH_AMP) || (c == CH_PIPE);
  endfunction

  function automatic logic forms_pair(input logic [7:0] first, input logic [7:0] second);
    logic ok;
    case (first)
      CH_PLUS:    ok = (second == CH_EQ) || (second == CH_PLUS);
      CH_MINUS:   ok = (second == CH_EQ) || (second == CH_MINUS);
      CH_STAR, CH_SLASH, CH_EQ, CH_LT, CH_GT, CH_BANG:
                  ok = (second == CH_EQ);
      CH_PERCENT: ok = (second == CH_D) || (second == CH_F) ||
                       (second == CH_C) || (second == CH_S);
      CH_BSLASH:  ok = (second == CH_N) || (second == CH_T) || (second == CH_R);
      CH_AMP:     ok = (second == CH_AMP);
      CH_PIPE:    ok = (second == CH_PIPE);
      default:    ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

### design/c_like_lexeme_splitter_top.sv
// lexeme splitter top level: byte classifier, scan state and result queue
//
//   channel | ports                          | word
//   --------+--------------------------------+---------------------------------
//   input   | in_valid, in_stall, in_data    | source byte and last-byte flag
//   output  | out_valid, out_stall, out_data | lexeme byte or end marker
//
// one input word per cycle is taken unless stalled; the classifier and scan
// state update sit between the scan registers and a FIFO_DEPTH-entry queue.
// a word yields zero, one or two output words; the output side drains one
// word per cycle unless stalled, so only runs of two-result words (last byte)
// slow intake. in_stall rises when the queue has fewer than two free entries.
// synchronous reset empties the queue and returns the scan to idle.
module c_like_lexeme_splitter_top #(
  parameter int DEPTH = lls_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lls_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lls_pkg::out_word_t out_data
);
  import lls_pkg::*;

`include "c_like_lexeme_splitter_top_defines.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_word_t        fifo_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  mode_t            mode_r, mode_nxt;
  logic [7:0]       opener_r, opener_nxt;

  logic       in_fire, out_fire;
  logic       kept, begins;
  logic [1:0] kind;
  logic [1:0] push_n;
  logic [PTR_W-1:0] wr_ptr_inc;
  out_word_t  res_byte, res_eos;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = count_r > CNT_W'(DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = fifo_r[rd_ptr_r];

  // classify the incoming byte against the open lexeme
  always_comb begin
    kept       = 1'b1;
    begins     = 1'b1;
    kind       = KIND_PUNCT;
    mode_nxt   = mode_r;
    opener_nxt = opener_r;
    if (mode_r == MODE_IDENT && (is_letter(in_data.char_in) || is_digit(in_data.char_in))) begin
      begins = 1'b0;
      kind   = KIND_IDENT;
    end else if (mode_r == MODE_NUMBER && is_digit(in_data.char_in)) begin
      begins = 1'b0;
      kind   = KIND_NUMBER;
    end else if (mode_r == MODE_PUNCT && forms_pair(opener_r, in_data.char_in)) begin
      // pair completes and closes the lexeme
      begins   = 1'b0;
      mode_nxt = MODE_IDLE;
    end else if (is_letter(in_data.char_in)) begin
      kind     = KIND_IDENT;
      mode_nxt = MODE_IDENT;
    end else if (is_digit(in_data.char_in)) begin
      kind     = KIND_NUMBER;
      mode_nxt = MODE_NUMBER;
    end else if (is_opener(in_data.char_in)) begin
      mode_nxt   = MODE_PUNCT;
      opener_nxt = in_data.char_in;
    end else if (is_single_punct(in_data.char_in)) begin
      mode_nxt = MODE_IDLE;
    end else begin
      kept     = 1'b0;
      mode_nxt = MODE_IDLE;
    end
    if (mode_nxt != MODE_PUNCT) begin
      opener_nxt = '0;
    end
    // end of text starts the next one from idle
    if (in_data.end_of_input) begin
      mode_nxt   = MODE_IDLE;
      opener_nxt = '0;
    end
  end

  always_comb begin
    res_byte.char_out      = in_data.char_in;
    res_byte.begins_lexeme = begins;
    res_byte.lexeme_kind   = kind;
    res_byte.end_of_stream = 1'b0;
    res_byte.last_of_run   = !in_data.end_of_input;
    res_eos.char_out       = '0;
    res_eos.begins_lexeme  = 1'b0;
    res_eos.lexeme_kind    = KIND_IDENT;
    res_eos.end_of_stream  = 1'b1;
    res_eos.last_of_run    = 1'b1;
  end

  always_comb begin
    push_n     = in_fire ? {1'b0, kept} + {1'b0, in_data.end_of_input} : 2'd0;
    wr_ptr_inc = ptr_inc(wr_ptr_r);
    case (push_n)
      2'd0:    wr_ptr_nxt = wr_ptr_r;
      2'd1:    wr_ptr_nxt = wr_ptr_inc;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_inc);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = out_fire ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push_n) - CNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      mode_r   <= MODE_IDLE;
      opener_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      if (in_fire) begin
        mode_r   <= mode_nxt;
        opener_r <= opener_nxt;
      end
    end
  end

  // queue entries carry no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (kept) begin
        fifo_r[wr_ptr_r] <= res_byte;
      end
      if (in_data.end_of_input) begin
        fifo_r[kept ? wr_ptr_inc : wr_ptr_r] <= res_eos;
      end
    end
  end

  `LLS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "queue count overflow")
  `LLS_ASSERT_NOW(a_eos_shape, out_valid && out_data.end_of_stream, out_data.last_of_run && out_data.char_out == 8'd0, "malformed end marker")
  `LLS_ASSERT_NEXT(a_idle_after_end, in_fire && in_data.end_of_input, mode_r == MODE_IDLE && opener_r == 8'd0, "scan not idle after end of text")
  `LLS_ASSERT_NEXT(a_pop_only, out_fire && !in_fire, count_r == $past(count_r) - 1'b1, "pop without push miscounted")

endmodule

### bench/tb_c_like_lexeme_splitter_top.sv
// self-checking bench for the lexeme splitter: directed table, random text, scoreboard
`timescale 1ns / 1ps

module tb_c_like_lexeme_splitter_top;
  import lls_pkg::*;

  localparam int DIR_ROWS   = 25;
  localparam int RAND_ITEMS = 1400;
  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_START = 700;
  localparam int HOLD_LEN   = 160;
  localparam int TAIL_WAIT  = 8;
  localparam int MAX_PRINTS = 200;

  typedef enum logic [2:0] {
    BC_ALPHA,
    BC_DIGIT,
    BC_SOLO,
    BC_OPENER,
    BC_OTHER
  } byte_class_t;

  // one source byte plus, for a few table rows, the words typed in by hand
  typedef struct packed {
    in_word_t   w;
    logic       typed;
    logic [1:0] n_typed;
    out_word_t  e0;
    out_word_t  e1;
  } text_row_t;

  localparam out_word_t NO_WORD  = '0;
  localparam out_word_t END_MARK = '{8'h00, 1'b0, KIND_IDENT, 1'b1, 1'b1};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  c_like_lexeme_splitter_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  text_row_t directed [DIR_ROWS];
  text_row_t stim_q [$];
  out_word_t lexeme_q [$];
  out_word_t fresh_q [$];

  logic [7:0] opener_chars [0:11] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_LT,
                                       CH_GT, CH_BANG, CH_PERCENT, CH_BSLASH, CH_AMP, CH_PIPE};
  logic [7:0] solo_chars [0:10] = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE,
                                     CH_RBRACE, CH_COMMA, CH_SEMI, CH_DOT, CH_SQUOTE, CH_DQUOTE};
  logic [7:0] sep_chars [0:3] = '{8'h20, 8'h09, 8'h0A, 8'h00};

  // scan state of the predictor
  mode_t      scan_st = MODE_IDLE;
  logic [7:0] open_ch = 8'h00;

  int err_count = 0;
  int feed_idx = 0;
  int taken_idx = 0;
  int words_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int drain_cyc = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int phase_left = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  task automatic report_error(input string msg);
    if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_error($sformatf("word %0d %s got %0h want %0h", words_seen, name, got, want));
  endtask

  function automatic byte_class_t classify(input logic [7:0] c);
    if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) || c == CH_UNDERSCORE)
      return BC_ALPHA;
    if (c >= CH_0 && c <= CH_9) return BC_DIGIT;
    case (c)
      CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE,
      CH_COMMA, CH_SEMI, CH_DOT, CH_SQUOTE, CH_DQUOTE:
        return BC_SOLO;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_LT, CH_GT, CH_BANG,
      CH_PERCENT, CH_BSLASH, CH_AMP, CH_PIPE:
        return BC_OPENER;
      default:
        return BC_OTHER;
    endcase
  endfunction

  function automatic logic pairs_with(input logic [7:0] a, input logic [7:0] b);
    case (a)
      CH_PLUS:    return b == CH_EQ || b == CH_PLUS;
      CH_MINUS:   return b == CH_EQ || b == CH_MINUS;
      CH_STAR, CH_SLASH, CH_EQ, CH_LT, CH_GT, CH_BANG:
                  return b == CH_EQ;
      CH_PERCENT: return b == CH_D || b == CH_F || b == CH_C || b == CH_S;
      CH_BSLASH:  return b == CH_N || b == CH_T || b == CH_R;
      CH_AMP:     return b == CH_AMP;
      CH_PIPE:    return b == CH_PIPE;
      default:    return 1'b0;
    endcase
  endfunction

  // advances the scan state by one source byte, leaves its words in fresh_q
  function automatic void predict_lexemes(input in_word_t w);
    byte_class_t cl;
    out_word_t   r;
    logic        keep;
    cl = classify(w.char_in);
    keep = 1'b1;
    r = '0;
    r.char_out = w.char_in;
    r.begins_lexeme = 1'b1;
    r.lexeme_kind = KIND_PUNCT;
    if (scan_st == MODE_IDENT && (cl == BC_ALPHA || cl == BC_DIGIT)) begin
      r.begins_lexeme = 1'b0;
      r.lexeme_kind = KIND_IDENT;
    end else if (scan_st == MODE_NUMBER && cl == BC_DIGIT) begin
      r.begins_lexeme = 1'b0;
      r.lexeme_kind = KIND_NUMBER;
    end else if (scan_st == MODE_PUNCT && pairs_with(open_ch, w.char_in)) begin
      // second byte of a pair closes the lexeme
      r.begins_lexeme = 1'b0;
      scan_st = MODE_IDLE;
    end else begin
      case (cl)
        BC_ALPHA: begin
          r.lexeme_kind = KIND_IDENT;
          scan_st = MODE_IDENT;
        end
        BC_DIGIT: begin
          r.lexeme_kind = KIND_NUMBER;
          scan_st = MODE_NUMBER;
        end
        BC_OPENER: begin
          scan_st = MODE_PUNCT;
          open_ch = w.char_in;
        end
        BC_SOLO: scan_st = MODE_IDLE;
        default: begin
          keep = 1'b0;
          scan_st = MODE_IDLE;
        end
      endcase
    end
    if (scan_st != MODE_PUNCT) open_ch = 8'h00;
    if (keep) begin
      r.last_of_run = !w.end_of_input;
      fresh_q.push_back(r);
    end
    if (w.end_of_input) begin
      fresh_q.push_back(END_MARK);
      scan_st = MODE_IDLE;
      open_ch = 8'h00;
    end
  endfunction

  function automatic text_row_t plain(input logic [7:0] c, input logic eoi);
    text_row_t row;
    row = '0;
    row.w.char_in = c;
    row.w.end_of_input = eoi;
    return row;
  endfunction

  function automatic text_row_t typed(input logic [7:0] c, input logic eoi, input logic [1:0] n,
                                      input out_word_t e0, input out_word_t e1);
    text_row_t row;
    row = plain(c, eoi);
    row.typed = 1'b1;
    row.n_typed = n;
    row.e0 = e0;
    row.e1 = e1;
    return row;
  endfunction

  function automatic logic [7:0] rand_alpha();
    int k;
    k = $urandom_range(0, 52);
    if (k < 26) return 8'(CH_UP_A + k);
    if (k < 52) return 8'(CH_LO_A + (k - 26));
    return CH_UNDERSCORE;
  endfunction

  function automatic logic [7:0] rand_word_char();
    if ($urandom_range(0, 3) == 0) return 8'(CH_0 + $urandom_range(0, 9));
    return rand_alpha();
  endfunction

  function automatic logic [7:0] partner_of(input logic [7:0] c);
    case (c)
      CH_PLUS:    return ($urandom_range(0, 1) == 0) ? CH_EQ : CH_PLUS;
      CH_MINUS:   return ($urandom_range(0, 1) == 0) ? CH_EQ : CH_MINUS;
      CH_PERCENT: begin
        case ($urandom_range(0, 3))
          0: return CH_D;
          1: return CH_F;
          2: return CH_C;
          default: return CH_S;
        endcase
      end
      CH_BSLASH: begin
        case ($urandom_range(0, 2))
          0: return CH_N;
          1: return CH_T;
          default: return CH_R;
        endcase
      end
      CH_AMP:     return CH_AMP;
      CH_PIPE:    return CH_PIPE;
      default:    return CH_EQ;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] c);
    stim_q.push_back(plain(c, $urandom_range(0, 39) == 0));
  endtask

  // mostly well-formed lexemes back to back, with separators and noise between
  task automatic add_random_lexeme();
    int pick;
    int len;
    int k;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      add_byte(rand_alpha());
      len = $urandom_range(0, 7);
      for (k = 0; k < len; k++) add_byte(rand_word_char());
    end else if (pick < 43) begin
      len = $urandom_range(1, 6);
      for (k = 0; k < len; k++) add_byte(8'(CH_0 + $urandom_range(0, 9)));
    end else if (pick < 63) begin
      c = opener_chars[4'($urandom_range(0, 11))];
      add_byte(c);
      if ($urandom_range(0, 9) < 6) add_byte(partner_of(c));
    end else if (pick < 73) begin
      add_byte(solo_chars[4'($urandom_range(0, 10))]);
    end else if (pick < 87) begin
      add_byte(sep_chars[2'($urandom_range(0, 3))]);
    end else begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin : feed
    logic took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) feed_idx++;
      if (in_valid && !took) begin
        // stalled word stays on the bus
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (feed_idx < stim_q.size()) begin
        in_valid <= 1'b1;
        in_data <= stim_q[feed_idx].w;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(40, 120);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = $urandom_range(0, 6);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall density changes per phase, plus one long hold-off
  always @(posedge clk) begin : drain
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      drain_cyc++;
      if (!hold_done && drain_cyc == HOLD_START) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_done = 1;
        out_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(8, 80);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            3: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        phase_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // prediction on input words, comparison on output words
  always @(posedge clk) begin : monitor
    text_row_t row;
    out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        row = stim_q[taken_idx];
        taken_idx++;
        predict_lexemes(in_data);
        if (row.typed) begin
          fresh_q.delete();
          if (row.n_typed > 0) lexeme_q.push_back(row.e0);
          if (row.n_typed > 1) lexeme_q.push_back(row.e1);
        end else begin
          while (fresh_q.size() > 0) lexeme_q.push_back(fresh_q.pop_front());
        end
      end
      if (out_valid && !out_stall) begin
        if (lexeme_q.size() == 0) begin
          report_error($sformatf("word %0d unexpected %h", words_seen, out_data));
        end else begin
          want = lexeme_q.pop_front();
          check_field("char_out", out_data.char_out, want.char_out);
          check_field("begins_lexeme", out_data.begins_lexeme, want.begins_lexeme);
          check_field("lexeme_kind", out_data.lexeme_kind, want.lexeme_kind);
          check_field("end_of_stream", out_data.end_of_stream, want.end_of_stream);
          check_field("last_of_run", out_data.last_of_run, want.last_of_run);
        end
        words_seen++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("c_like_lexeme_splitter_top verification failed");
        $finish;
      end
    end
  end

  initial begin : run
    int k;
    directed = '{
      typed(CH_UP_A, 1'b0, 2'd1, '{CH_UP_A, 1'b1, KIND_IDENT, 1'b0, 1'b1}, NO_WORD),
      plain(CH_LO_Z, 1'b0),
      plain(CH_UNDERSCORE, 1'b0),
      plain(CH_9, 1'b0),
      typed(8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD),
      typed(CH_0, 1'b0, 2'd1, '{CH_0, 1'b1, KIND_NUMBER, 1'b0, 1'b1}, NO_WORD),
      plain(CH_9, 1'b0),
      plain(CH_LO_A, 1'b0),
      plain(CH_PLUS, 1'b0),
      plain(CH_PLUS, 1'b0),
      plain(CH_PLUS, 1'b0),
      plain(CH_LT, 1'b0),
      plain(CH_EQ, 1'b0),
      plain(CH_PERCENT, 1'b0),
      plain(CH_D, 1'b0),
      plain(CH_BSLASH, 1'b0),
      plain(CH_N, 1'b0),
      plain(CH_AMP, 1'b0),
      plain(CH_AMP, 1'b0),
      plain(CH_PIPE, 1'b0),
      plain(CH_LBRACE, 1'b0),
      typed(CH_BANG, 1'b1, 2'd2, '{CH_BANG, 1'b1, KIND_PUNCT, 1'b0, 1'b0}, END_MARK),
      plain(CH_EQ, 1'b0),
      typed(8'hFF, 1'b1, 2'd1, END_MARK, NO_WORD),
      plain(8'h80, 1'b0)
    };
    for (k = 0; k < DIR_ROWS; k++) stim_q.push_back(directed[k]);
    while (stim_q.size() < DIR_ROWS + RAND_ITEMS) add_random_lexeme();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (taken_idx == stim_q.size());
    wait (lexeme_q.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (lexeme_q.size() != 0)
      report_error($sformatf("%0d expected words never arrived", lexeme_q.size()));

    if (err_count == 0) begin
      $display("c_like_lexeme_splitter_top verification clean");
    end else begin
      $display("c_like_lexeme_splitter_top verification failed");
    end
    $finish;
  end

endmodule
